@@ rtl/dcfe_pkg.sv @@
// Shared types, codes and CRC functions for the daisy-chain frame engine.
`default_nettype none

package dcfe_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_RANGE = 3'd1;
  localparam logic [2:0] ST_ECHO  = 3'd2;
  localparam logic [2:0] ST_CRC   = 3'd3;
  localparam logic [2:0] ST_CNT   = 3'd4;
  localparam logic [2:0] ST_UNEXP = 3'd5;

  // Request types
  localparam logic [1:0] REQ_NOP    = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_WRITE  = 2'd2;
  localparam logic [1:0] REQ_GWRITE = 2'd3;

  // Frame constants
  localparam logic [7:0] CRC_INIT = 8'h42;
  localparam logic [7:0] CRC_POLY = 8'h2F;
  localparam logic [7:0] CC_MASK  = 8'hF3;
  localparam logic [7:0] ADDR_MAX = 8'h7F;

  // Classified transaction handed from front to back
  typedef struct packed {
    logic        is_frame;   // received frame, else request
    logic        range_err;  // request failed its range check
    logic [47:0] frame;      // tx frame for a request, rx frame otherwise
    logic [7:0]  left;       // responses expected for a read
    logic        crc_ok;     // rx frame CRC matches
  } item_t;

  // One result as held in the output register
  typedef struct packed {
    logic [2:0]  status;
    logic        frame_valid;
    logic [47:0] frame;
    logic        data_valid;
    logic [15:0] reg_data;
    logic        done;
  } res_t;

  // One byte through the CRC-8 register, MSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // CRC over the five leading frame bytes, data high byte first
  function automatic logic [7:0] crc_frame(input logic [39:0] msg);
    logic [7:0] c;
    c = CRC_INIT;
    for (int k = 4; k >= 0; k--) begin
      c = crc_byte(c, msg[k*8 +: 8]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dcfe_front.sv @@
// Front end: classifies an incoming transaction and builds request frames.
`default_nettype none

module dcfe_front (
  input  wire logic          cmd,
  input  wire logic [1:0]    req_type,
  input  wire logic [7:0]    reg_addr,
  input  wire logic [5:0]    cluster_id,
  input  wire logic [15:0]   reg_value,
  input  wire logic [15:0]   rx_data,
  input  wire logic [7:0]    rx_addr,
  input  wire logic [7:0]    rx_cid,
  input  wire logic [7:0]    rx_cnt_cmd,
  input  wire logic [7:0]    rx_crc,
  output dcfe_pkg::item_t    item
);

  always_comb begin
    logic [15:0] data;
    logic [6:0]  addr7;
    logic [5:0]  cid;
    logic [7:0]  cc;
    logic [16:0] span_end;
    logic        rerr;
    logic [39:0] tx_msg;

    // Request frame fields
    data  = reg_value;
    addr7 = reg_addr[6:0];
    cid   = cluster_id;
    cc    = {6'd0, req_type} & dcfe_pkg::CC_MASK;
    rerr  = 1'b0;
    span_end = {9'd0, reg_addr} + {1'b0, reg_value};

    case (req_type)
      dcfe_pkg::REQ_NOP: begin
        data  = '0;
        addr7 = '0;
      end
      dcfe_pkg::REQ_READ: begin
        // last register addressed must stay within the map
        rerr = (reg_addr > dcfe_pkg::ADDR_MAX) || (reg_value == '0) ||
               (span_end > 17'd128);
      end
      dcfe_pkg::REQ_GWRITE: begin
        rerr = reg_addr > dcfe_pkg::ADDR_MAX;
        cid  = '0;
      end
      default: begin
        rerr = reg_addr > dcfe_pkg::ADDR_MAX;
      end
    endcase

    tx_msg = {data, 1'b0, addr7, 2'b00, cid, cc};

    item.is_frame  = cmd;
    item.range_err = rerr;
    item.left      = (req_type == dcfe_pkg::REQ_READ) ? reg_value[7:0] : 8'd0;
    item.crc_ok    = dcfe_pkg::crc_frame({rx_data, rx_addr, rx_cid, rx_cnt_cmd}) == rx_crc;
    if (cmd) begin
      item.frame = {rx_data, rx_addr, rx_cid, rx_cnt_cmd, rx_crc};
    end else begin
      item.frame = {tx_msg, dcfe_pkg::crc_frame(tx_msg)};
    end
  end

endmodule

`default_nettype wire

@@ rtl/dcfe_queue.sv @@
// Two-entry queue between the front end and the back end.
`default_nettype none

module dcfe_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire dcfe_pkg::item_t wr_item,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output dcfe_pkg::item_t      rd_item
);

  dcfe_pkg::item_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_item = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_item;
  end

endmodule

`default_nettype wire

@@ rtl/dcfe_back.sv @@
// Back end: transaction state machine, message counters and result register.
`default_nettype none

module dcfe_back #(
  parameter int CLUSTERS = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dcfe_pkg::item_t q_item,
  input  wire logic            q_empty,
  output logic                 pop,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output dcfe_pkg::res_t       res
);

  localparam int IDX_W = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;

  typedef enum logic [1:0] {PH_IDLE, PH_ECHO, PH_RESP} phase_t;

  phase_t         phase, phase_next;
  logic [47:0]    sent_frame, sent_frame_next;
  logic [7:0]     left, left_next;
  logic [5:0]     active, active_next;
  dcfe_pkg::res_t res_next;

  // Counter store and its read path
  logic [3:0]     cnt_mem [CLUSTERS];
  logic           cnt_vld [CLUSTERS];
  logic [3:0]     rd_q;
  logic           rd_vld_q;
  logic           load_q;
  logic [3:0]     cur_cnt;
  logic           rd_en;
  logic           mem_we;
  logic [3:0]     rcv;
  logic           has_ctr;
  logic           fire;

  assign fire    = !q_empty && (!out_valid || out_ready);
  assign pop     = fire;
  assign rcv     = q_item.frame[15:12];
  assign has_ctr = {1'b0, active} < 7'(CLUSTERS);

  // Next-state and result decode
  always_comb begin
    phase_next      = phase;
    sent_frame_next = sent_frame;
    left_next       = left;
    active_next     = active;
    res_next        = '0;
    rd_en           = 1'b0;
    mem_we          = 1'b0;

    if (fire) begin
      if (!q_item.is_frame) begin
        if (phase != PH_IDLE) begin
          res_next.status = dcfe_pkg::ST_UNEXP;
        end else if (q_item.range_err) begin
          res_next.status = dcfe_pkg::ST_RANGE;
          res_next.done   = 1'b1;
        end else begin
          res_next.frame_valid = 1'b1;
          res_next.frame       = q_item.frame;
          sent_frame_next      = q_item.frame;
          left_next            = q_item.left;
          active_next          = q_item.frame[21:16];
          phase_next           = PH_ECHO;
          rd_en                = 1'b1;
        end
      end else begin
        unique case (phase)
          PH_IDLE: begin
            res_next.status = dcfe_pkg::ST_UNEXP;
          end
          PH_ECHO: begin
            if (q_item.frame != sent_frame) begin
              res_next.status = dcfe_pkg::ST_ECHO;
              res_next.done   = 1'b1;
              phase_next      = PH_IDLE;
            end else if (left == '0) begin
              res_next.done = 1'b1;
              phase_next    = PH_IDLE;
            end else begin
              phase_next = PH_RESP;
            end
          end
          PH_RESP: begin
            if (!q_item.crc_ok) begin
              res_next.status = dcfe_pkg::ST_CRC;
              res_next.done   = 1'b1;
              phase_next      = PH_IDLE;
            end else begin
              // counter is stored even when the check fails
              mem_we = has_ctr;
              if (has_ctr && active != '0 && rcv != 4'(cur_cnt + 4'd1)) begin
                res_next.status = dcfe_pkg::ST_CNT;
                res_next.done   = 1'b1;
                phase_next      = PH_IDLE;
              end else begin
                res_next.data_valid = 1'b1;
                res_next.reg_data   = q_item.frame[47:32];
                left_next           = 8'(left - 8'd1);
                if (left == 8'd1) begin
                  res_next.done = 1'b1;
                  phase_next    = PH_IDLE;
                end
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      sent_frame <= '0;
      left       <= '0;
      active     <= '0;
      out_valid  <= 1'b0;
      load_q     <= 1'b0;
    end else begin
      phase      <= phase_next;
      sent_frame <= sent_frame_next;
      left       <= left_next;
      active     <= active_next;
      load_q     <= rd_en;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (fire) res <= res_next;
  end

  // Counter memory: read on issue, written on each response with a good CRC
  always_ff @(posedge clk) begin
    if (mem_we) cnt_mem[active[IDX_W-1:0]] <= rcv;
    if (rd_en) rd_q <= cnt_mem[q_item.frame[16 +: IDX_W]];
  end

  // Written flags stand in for the all-zero reset of the store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLUSTERS; i++) cnt_vld[i] <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) cnt_vld[active[IDX_W-1:0]] <= 1'b1;
      if (rd_en) rd_vld_q <= cnt_vld[q_item.frame[16 +: IDX_W]];
    end
  end

  // Counter of the active cluster, loaded from the registered read rd_q
  always_ff @(posedge clk) begin
    if (load_q) begin
      cur_cnt <= rd_vld_q ? rd_q : 4'd0;
    end else if (mem_we) begin
      cur_cnt <= rcv;
    end
  end

endmodule

`default_nettype wire

@@ rtl/daisy_chain_frame_engine.sv @@
// Top level of the daisy-chain frame engine: front end, queue and back end.
`default_nettype none

// Master side of a CRC-8 framed register-access link. Each input transaction
// is either a request (nop, read of N registers, write, global write), which
// is range checked and returned as a 48-bit transmit frame with its CRC, or a
// received frame, checked first as the echo of the sent frame and then as
// one response per register read (CRC, then the 4-bit per-cluster message
// counter; cluster 0 skips the counter check). Every input transaction gives
// exactly one result. The engine takes one transaction per clock cycle while
// in_ready is high. The front end classifies and computes CRCs in the
// acceptance cycle, a two-entry queue registers the classified transaction,
// and the back end's state update then writes the output register, which
// presents the result. When the output is held off, the queue fills and
// in_ready drops until a result is taken. The counter store needs
// no clearing pass after reset; per-cluster written flags give the zero
// reset value.
module daisy_chain_frame_engine #(
  parameter int CLUSTERS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  reg_addr,
  input  wire logic [5:0]  cluster_id,
  input  wire logic [15:0] reg_value,
  input  wire logic [15:0] rx_data,
  input  wire logic [7:0]  rx_addr,
  input  wire logic [7:0]  rx_cid,
  input  wire logic [7:0]  rx_cnt_cmd,
  input  wire logic [7:0]  rx_crc,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic             frame_valid,
  output logic [15:0]      tx_data,
  output logic [6:0]       tx_addr,
  output logic [5:0]       tx_cid,
  output logic [7:0]       tx_cnt_cmd,
  output logic [7:0]       tx_crc,
  output logic             data_valid,
  output logic [15:0]      reg_data,
  output logic             done_res
);

  dcfe_pkg::item_t f_item;
  dcfe_pkg::item_t q_item;
  dcfe_pkg::res_t  res;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic            q_push;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Classification
  dcfe_front u_front (
    .cmd        (cmd),
    .req_type   (req_type),
    .reg_addr   (reg_addr),
    .cluster_id (cluster_id),
    .reg_value  (reg_value),
    .rx_data    (rx_data),
    .rx_addr    (rx_addr),
    .rx_cid     (rx_cid),
    .rx_cnt_cmd (rx_cnt_cmd),
    .rx_crc     (rx_crc),
    .item       (f_item)
  );

  // Decoupling queue
  dcfe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (f_item),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .rd_item (q_item)
  );

  // Transaction execution
  dcfe_back #(
    .CLUSTERS (CLUSTERS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_item),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res       (res)
  );

  // Result fields
  assign status      = res.status;
  assign frame_valid = res.frame_valid;
  assign tx_data     = res.frame[47:32];
  assign tx_addr     = res.frame[30:24];
  assign tx_cid      = res.frame[21:16];
  assign tx_cnt_cmd  = res.frame[15:8];
  assign tx_crc      = res.frame[7:0];
  assign data_valid  = res.data_valid;
  assign reg_data    = res.reg_data;
  assign done_res    = res.done;

`ifndef SYNTH
  a_frame_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_valid |-> status == dcfe_pkg::ST_OK && !done_res && !data_valid)
    else $error("transmit frame with error status");

  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_valid |-> status == dcfe_pkg::ST_OK)
    else $error("register data with error status");

  a_unexp_nodone: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dcfe_pkg::ST_UNEXP |-> !done_res && !frame_valid)
    else $error("unexpected transaction ended the running one");
`endif

endmodule

`default_nettype wire

@@ tb/link_result_checker.sv @@
// Scoreboard for the daisy-chain frame engine: predicts each result and checks the output channel.
module link_result_checker #(
  parameter int CLUSTERS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        cmd,
  input  logic [1:0]  req_type,
  input  logic [7:0]  reg_addr,
  input  logic [5:0]  cluster_id,
  input  logic [15:0] reg_value,
  input  logic [15:0] rx_data,
  input  logic [7:0]  rx_addr,
  input  logic [7:0]  rx_cid,
  input  logic [7:0]  rx_cnt_cmd,
  input  logic [7:0]  rx_crc,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic        frame_valid,
  input  logic [15:0] tx_data,
  input  logic [6:0]  tx_addr,
  input  logic [5:0]  tx_cid,
  input  logic [7:0]  tx_cnt_cmd,
  input  logic [7:0]  tx_crc,
  input  logic        data_valid,
  input  logic [15:0] reg_data,
  input  logic        done_res,
  output int          failures,
  output int          outstanding,
  output int          results_checked,
  output int          data_results,
  output int          error_results
);

  typedef enum logic [1:0] {LINK_IDLE, LINK_ECHO, LINK_RESP} link_phase_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        frame_valid;
    logic [15:0] tx_data;
    logic [6:0]  tx_addr;
    logic [5:0]  tx_cid;
    logic [7:0]  tx_cnt_cmd;
    logic [7:0]  tx_crc;
    logic        data_valid;
    logic [15:0] reg_data;
    logic        done_res;
  } link_result_t;

  // Link state as the engine should hold it
  link_phase_t  phase_q;
  logic [47:0]  sent_q;
  logic [7:0]   left_q;
  logic [5:0]   cluster_q;
  logic [3:0]   counter_mem [CLUSTERS];

  link_result_t pending_results [$];
  link_result_t want;

  // CRC-8 shifted one message bit at a time, MSB first
  function automatic logic [7:0] frame_crc(input logic [39:0] msg);
    logic [7:0] c;
    logic       fb;
    c = dcfe_pkg::CRC_INIT;
    for (int i = 39; i >= 0; i--) begin
      fb = c[7] ^ msg[i];
      c  = {c[6:0], 1'b0};
      if (fb) c = c ^ dcfe_pkg::CRC_POLY;
    end
    return c;
  endfunction

  task automatic reset_link_model();
    phase_q   = LINK_IDLE;
    sent_q    = '0;
    left_q    = '0;
    cluster_q = '0;
    for (int k = 0; k < CLUSTERS; k++) counter_mem[k] = 4'd0;
  endtask

  // Expected result of one transaction; advances the link state
  function automatic link_result_t predict_result(input logic c, input logic [1:0] t,
      input logic [7:0] addr, input logic [5:0] cid, input logic [15:0] val,
      input logic [47:0] rx);
    link_result_t r;
    logic [15:0]  data;
    logic [6:0]   a7;
    logic [5:0]   fcid;
    logic [7:0]   cc;
    logic [7:0]   crc;
    logic [3:0]   prev;
    logic [3:0]   rcv;
    r = '0;
    if (!c) begin
      if (phase_q != LINK_IDLE) begin
        r.status = dcfe_pkg::ST_UNEXP;
        return r;
      end
      if (t != dcfe_pkg::REQ_NOP && (addr > dcfe_pkg::ADDR_MAX ||
          (t == dcfe_pkg::REQ_READ && (val == 16'd0 ||
           int'(addr) + int'(val) - 1 > int'(dcfe_pkg::ADDR_MAX))))) begin
        r.status   = dcfe_pkg::ST_RANGE;
        r.done_res = 1'b1;
        return r;
      end
      data = (t == dcfe_pkg::REQ_NOP) ? 16'd0 : val;
      a7   = (t == dcfe_pkg::REQ_NOP) ? 7'd0 : addr[6:0];
      fcid = (t == dcfe_pkg::REQ_GWRITE) ? 6'd0 : cid;
      cc   = {6'd0, t} & dcfe_pkg::CC_MASK;
      crc  = frame_crc({data, 1'b0, a7, 2'b00, fcid, cc});
      sent_q    = {data, 1'b0, a7, 2'b00, fcid, cc, crc};
      left_q    = (t == dcfe_pkg::REQ_READ) ? val[7:0] : 8'd0;
      cluster_q = fcid;
      phase_q   = LINK_ECHO;
      r.frame_valid = 1'b1;
      r.tx_data     = data;
      r.tx_addr     = a7;
      r.tx_cid      = fcid;
      r.tx_cnt_cmd  = cc;
      r.tx_crc      = crc;
      return r;
    end
    if (phase_q == LINK_IDLE) begin
      r.status = dcfe_pkg::ST_UNEXP;
      return r;
    end
    // echo must repeat the sent frame exactly
    if (phase_q == LINK_ECHO) begin
      if (rx != sent_q) begin
        r.status   = dcfe_pkg::ST_ECHO;
        r.done_res = 1'b1;
        phase_q    = LINK_IDLE;
      end else if (left_q == 8'd0) begin
        r.done_res = 1'b1;
        phase_q    = LINK_IDLE;
      end else begin
        phase_q = LINK_RESP;
      end
      return r;
    end
    // register response: crc, then message counter
    if (frame_crc(rx[47:8]) != rx[7:0]) begin
      r.status   = dcfe_pkg::ST_CRC;
      r.done_res = 1'b1;
      phase_q    = LINK_IDLE;
      return r;
    end
    if (int'(cluster_q) < CLUSTERS) begin
      prev = counter_mem[cluster_q];
      rcv  = rx[15:12];
      counter_mem[cluster_q] = rcv;
      if (cluster_q != 6'd0 && rcv != prev + 4'd1) begin
        r.status   = dcfe_pkg::ST_CNT;
        r.done_res = 1'b1;
        phase_q    = LINK_IDLE;
        return r;
      end
    end
    r.data_valid = 1'b1;
    r.reg_data   = rx[47:32];
    left_q = left_q - 8'd1;
    if (left_q == 8'd0) begin
      r.done_res = 1'b1;
      phase_q    = LINK_IDLE;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      failures++;
    end
  endtask

  // Retire results first, then queue the prediction for a newly accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      reset_link_model();
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (data_valid === 1'b1) data_results++;
        if (status !== dcfe_pkg::ST_OK) error_results++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with no transaction pending, expected none, actual status %0d",
                   $time, status);
          failures++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", 16'(want.status), 16'(status));
          compare_field("frame_valid", 16'(want.frame_valid), 16'(frame_valid));
          compare_field("tx_data", want.tx_data, tx_data);
          compare_field("tx_addr", 16'(want.tx_addr), 16'(tx_addr));
          compare_field("tx_cid", 16'(want.tx_cid), 16'(tx_cid));
          compare_field("tx_cnt_cmd", 16'(want.tx_cnt_cmd), 16'(tx_cnt_cmd));
          compare_field("tx_crc", 16'(want.tx_crc), 16'(tx_crc));
          compare_field("data_valid", 16'(want.data_valid), 16'(data_valid));
          compare_field("reg_data", want.reg_data, reg_data);
          compare_field("done_res", 16'(want.done_res), 16'(done_res));
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(predict_result(cmd, req_type, reg_addr, cluster_id,
            reg_value, {rx_data, rx_addr, rx_cid, rx_cnt_cmd, rx_crc}));
      end
    end
    outstanding = pending_results.size();
  end

endmodule

@@ tb/daisy_chain_frame_engine_test.sv @@
// Testbench top for the daisy-chain frame engine: stimulus, flow control and verdict.
module daisy_chain_frame_engine_test;

  localparam int CLUSTERS     = 64;
  localparam int RANDOM_ITEMS = 1900;
  localparam int HOLD_CYCLES  = 60;
  localparam int CYCLE_LIMIT  = 300000;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        cmd        = 1'b0;
  logic [1:0]  req_type   = dcfe_pkg::REQ_NOP;
  logic [7:0]  reg_addr   = 8'd0;
  logic [5:0]  cluster_id = 6'd0;
  logic [15:0] reg_value  = 16'd0;
  logic [15:0] rx_data    = 16'd0;
  logic [7:0]  rx_addr    = 8'd0;
  logic [7:0]  rx_cid     = 8'd0;
  logic [7:0]  rx_cnt_cmd = 8'd0;
  logic [7:0]  rx_crc     = 8'd0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [2:0]  status;
  logic        frame_valid;
  logic [15:0] tx_data;
  logic [6:0]  tx_addr;
  logic [5:0]  tx_cid;
  logic [7:0]  tx_cnt_cmd;
  logic [7:0]  tx_crc;
  logic        data_valid;
  logic [15:0] reg_data;
  logic        done_res;

  int   failures;
  int   outstanding;
  int   results_checked;
  int   data_results;
  int   error_results;
  int   send_idle_pct = 27;
  int   recv_idle_pct = 66;
  int   items_sent    = 0;
  int   cycle_count   = 0;
  logic long_hold     = 1'b0;

  // Message counters as the link side will see them, for building good responses
  logic [3:0] link_counter [CLUSTERS];

  daisy_chain_frame_engine #(.CLUSTERS(CLUSTERS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .req_type(req_type), .reg_addr(reg_addr), .cluster_id(cluster_id),
    .reg_value(reg_value), .rx_data(rx_data), .rx_addr(rx_addr), .rx_cid(rx_cid),
    .rx_cnt_cmd(rx_cnt_cmd), .rx_crc(rx_crc),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .frame_valid(frame_valid), .tx_data(tx_data), .tx_addr(tx_addr),
    .tx_cid(tx_cid), .tx_cnt_cmd(tx_cnt_cmd), .tx_crc(tx_crc),
    .data_valid(data_valid), .reg_data(reg_data), .done_res(done_res)
  );

  link_result_checker #(.CLUSTERS(CLUSTERS)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .req_type(req_type), .reg_addr(reg_addr), .cluster_id(cluster_id),
    .reg_value(reg_value), .rx_data(rx_data), .rx_addr(rx_addr), .rx_cid(rx_cid),
    .rx_cnt_cmd(rx_cnt_cmd), .rx_crc(rx_crc),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .frame_valid(frame_valid), .tx_data(tx_data), .tx_addr(tx_addr),
    .tx_cid(tx_cid), .tx_cnt_cmd(tx_cnt_cmd), .tx_crc(tx_crc),
    .data_valid(data_valid), .reg_data(reg_data), .done_res(done_res),
    .failures(failures), .outstanding(outstanding), .results_checked(results_checked),
    .data_results(data_results), .error_results(error_results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output side flow control
  always @(negedge clk) begin
    if (long_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // One long output stall while the input keeps coming, to fill the engine
  initial begin
    int held;
    wait (items_sent >= 400);
    @(posedge clk);
    long_hold = 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    long_hold = 1'b0;
  end

  // CRC-8 over five frame bytes, high byte first
  function automatic logic [7:0] link_crc(input logic [39:0] msg);
    logic [7:0] c;
    c = dcfe_pkg::CRC_INIT;
    for (int k = 4; k >= 0; k--) begin
      c = c ^ msg[k*8 +: 8];
      repeat (8) c = c[7] ? ((c << 1) ^ dcfe_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  // Present one transaction at a falling edge and hold it until accepted
  task automatic offer(input logic c, input logic [1:0] t, input logic [7:0] addr,
                       input logic [5:0] cid, input logic [15:0] val, input logic [47:0] rx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cmd        = c;
    req_type   = t;
    reg_addr   = addr;
    cluster_id = cid;
    reg_value  = val;
    {rx_data, rx_addr, rx_cid, rx_cnt_cmd, rx_crc} = rx;
    in_valid   = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_request(input logic [1:0] t, input logic [7:0] addr,
                              input logic [5:0] cid, input logic [15:0] val);
    offer(1'b0, t, addr, cid, val, rand48());
  endtask

  task automatic send_frame(input logic [47:0] rx);
    offer(1'b1, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
          6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)), rx);
  endtask

  task automatic send_busy_request();
    send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)));
  endtask

  // Request, its echo and, for a read, one response per register.
  // echo_flip >= 0 corrupts that echo bit; bad_at marks the response that
  // carries a crc fault (bad_crc) or a counter fault.
  task automatic run_transfer(input logic [1:0] t, input logic [7:0] addr,
                              input logic [5:0] cid, input logic [15:0] val,
                              input logic busy_req, input int echo_flip,
                              input int bad_at, input logic bad_crc);
    logic [15:0] data;
    logic [6:0]  a7;
    logic [5:0]  fcid;
    logic [7:0]  cc;
    logic [39:0] head;
    logic [47:0] frame;
    data = (t == dcfe_pkg::REQ_NOP) ? 16'd0 : val;
    a7   = (t == dcfe_pkg::REQ_NOP) ? 7'd0 : addr[6:0];
    fcid = (t == dcfe_pkg::REQ_GWRITE) ? 6'd0 : cid;
    cc   = {6'd0, t} & dcfe_pkg::CC_MASK;
    head = {data, 1'b0, a7, 2'b00, fcid, cc};
    send_request(t, addr, cid, val);
    if (busy_req) send_busy_request();
    frame = {head, link_crc(head)};
    if (echo_flip >= 0) frame[echo_flip] = ~frame[echo_flip];
    send_frame(frame);
    if (echo_flip >= 0 || t != dcfe_pkg::REQ_READ) return;
    for (int i = 0; i < int'(val); i++) begin
      frame = rand48();
      if (fcid != 6'd0) frame[15:12] = link_counter[fcid] + 4'd1;
      if (i == bad_at && !bad_crc) frame[15:12] = frame[15:12] + 4'($urandom_range(1, 15));
      frame[7:0] = link_crc(frame[47:8]);
      if (i == bad_at && bad_crc) frame[7:0] = frame[7:0] ^ 8'($urandom_range(1, 255));
      send_frame(frame);
      if (i == bad_at && bad_crc) return;
      // counter is kept even when its check fails
      link_counter[fcid] = frame[15:12];
      if (i == bad_at && fcid != 6'd0) return;
      if ($urandom_range(0, 49) == 0) send_busy_request();
    end
  endtask

  // One random sequence: mostly complete transfers, some noise and range errors
  task automatic random_transfer();
    int          r;
    int          n;
    logic [1:0]  t;
    logic [7:0]  addr;
    logic [5:0]  cid;
    logic [15:0] val;
    n   = 1;
    r   = $urandom_range(0, 99);
    cid = ($urandom_range(0, 7) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
    val = 16'($urandom_range(0, 65535));
    if (r < 7) begin
      send_frame(rand48());
    end else if (r < 15) begin
      addr = 8'($urandom_range(0, 127));
      case ($urandom_range(0, 2))
        0: begin
          t    = 2'($urandom_range(1, 3));
          addr = 8'($urandom_range(128, 255));
        end
        1: begin
          t   = dcfe_pkg::REQ_READ;
          val = 16'd0;
        end
        default: begin
          t   = dcfe_pkg::REQ_READ;
          val = 16'($urandom_range(129 - int'(addr), 65535));
        end
      endcase
      send_request(t, addr, cid, val);
    end else begin
      t    = 2'($urandom_range(0, 3));
      addr = (t == dcfe_pkg::REQ_NOP) ? 8'($urandom_range(0, 255)) :
                                        8'($urandom_range(0, 127));
      if (t == dcfe_pkg::REQ_READ) begin
        r = $urandom_range(0, 99);
        if (r < 85) n = $urandom_range(1, 4);
        else if (r < 97) n = $urandom_range(1, 16);
        else n = $urandom_range(1, 128);
        val  = 16'(n);
        addr = 8'($urandom_range(0, 128 - n));
      end
      run_transfer(t, addr, cid, val, $urandom_range(0, 9) == 0,
                   ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 47)) : -1,
                   (t == dcfe_pkg::REQ_READ && $urandom_range(0, 9) == 0) ?
                     int'($urandom_range(0, n - 1)) : -1,
                   1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int random_start;
    for (int k = 0; k < CLUSTERS; k++) link_counter[k] = 4'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corner cases
    send_frame(rand48());                                           // frame while idle
    run_transfer(dcfe_pkg::REQ_NOP, 8'hFF, 6'd63, 16'hFFFF, 1'b0, -1, -1, 1'b0);
    run_transfer(dcfe_pkg::REQ_WRITE, 8'h7F, 6'd63, 16'hFFFF, 1'b1, -1, -1,
                 1'b0);                                             // request while busy
    send_request(dcfe_pkg::REQ_WRITE, 8'h80, 6'd1, 16'h1234);       // address out of range
    send_request(dcfe_pkg::REQ_GWRITE, 8'hFF, 6'd2, 16'h0000);
    send_request(dcfe_pkg::REQ_READ, 8'd0, 6'd3, 16'd0);            // zero count
    send_request(dcfe_pkg::REQ_READ, 8'd120, 6'd3, 16'd9);          // last address past range
    run_transfer(dcfe_pkg::REQ_READ, 8'h7F, 6'd63, 16'd1, 1'b0, -1, -1, 1'b0);
    run_transfer(dcfe_pkg::REQ_GWRITE, 8'd0, 6'd42, 16'h0000, 1'b0, 17, -1,
                 1'b0);                                             // echo mismatch
    run_transfer(dcfe_pkg::REQ_READ, 8'd0, 6'd5, 16'd2, 1'b0, -1, 1,
                 1'b1);                                             // response crc fault
    run_transfer(dcfe_pkg::REQ_READ, 8'd10, 6'd5, 16'd2, 1'b0, -1, 0,
                 1'b0);                                             // counter fault
    run_transfer(dcfe_pkg::REQ_READ, 8'd126, 6'd0, 16'd2, 1'b0, -1, 0,
                 1'b0);                                             // cluster 0, no check

    // Random sequences under three flow-control mixes
    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      if (items_sent >= random_start + RANDOM_ITEMS * 2 / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= random_start + RANDOM_ITEMS / 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 27;
      end
      random_transfer();
    end
    in_valid = 1'b0;

    // Drain, then wait a while for any stray result
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Ran %0d transactions: directed corners, then random request/echo/response",
             items_sent);
    $display("sequences; %0d results checked, %0d register values, %0d error results.",
             results_checked, data_results, error_results);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
